### rtl/dcbg_pkg.sv
// Shared types and constants for the DC-blocking gain and saturate block.
package dcbg_pkg;

	// Filter coefficient, unsigned Q0.16 (about 0.995)
	localparam logic [15:0] ALPHA_Q16 = 16'd65208;
	// Gain register value after reset (1.0 in Q8.8)
	localparam logic [15:0] GAIN_RESET = 16'd256;
	// Saturation thresholds on the Q.22 magnitude
	localparam logic [47:0] POS_LIMIT = 48'(32767) << 22;
	localparam logic [47:0] NEG_LIMIT = 48'(32768) << 22;
	// Saturation limits for the filter state magnitude
	localparam logic [32:0] Y_POS_MAX = 33'h0_7FFF_FFFF;
	localparam logic [32:0] Y_NEG_MAX = 33'h0_8000_0000;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               last_in_buffer;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] sample_out;
		logic               clipped;
		logic               last_out;
	} out_item_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic calc_sum;
		logic calc_alpha;
		logic calc_gain;
		logic load_out;
	} dp_cmd_t;

endpackage

### rtl/dcbg_datapath.sv
// Datapath: per-channel filter history, two multiplies, saturation and output register.
module dcbg_datapath import dcbg_pkg::*; #(
	parameter int NUM_CHANNELS = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	input  in_item_t         in_item,
	input  logic             gain_we,
	input  logic [15:0]      gain_wdata,
	output out_item_t        out_item
);

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CHANNELS - 1);

	logic [15:0]               gain_q;
	logic [CH_W-1:0]           chan_pos_q;
	logic [CH_W-1:0]           ch_q;
	logic signed [15:0]        x_q;
	logic                      last_q;
	logic signed [15:0]        prev_x_q [NUM_CHANNELS];
	logic signed [31:0]        prev_y_q [NUM_CHANNELS];
	logic [32:0]               smag_s1;
	logic                      sneg_s1;
	logic [31:0]               ymag_s2;
	logic                      yneg_s2;
	logic [47:0]               vmag_s3;
	logic                      vneg_s3;
	out_item_t                 out_q;

	logic [CH_W-1:0]           ch_sel;
	logic signed [16:0]        diff;
	logic signed [32:0]        sum;
	logic [48:0]               alpha_prod;
	logic [32:0]               ym;
	logic [31:0]               ymag_sat;
	logic signed [31:0]        y_new;
	logic [15:0]               q;
	out_item_t                 out_next;

	// Gain register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (gain_we) begin
			gain_q <= gain_wdata;
		end
	end

	// Channel counter: restart after a last marker, wrap after the top channel
	always_comb begin
		ch_sel = (chan_pos_q > CH_LAST) ? '0 : chan_pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_pos_q <= '0;
		end else if (cmd.accept) begin
			if (in_item.last_in_buffer || ch_sel == CH_LAST) begin
				chan_pos_q <= '0;
			end else begin
				chan_pos_q <= ch_sel + CH_W'(1);
			end
		end
	end

	// Capture the input item
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q    <= in_item.sample;
			last_q <= in_item.last_in_buffer;
			ch_q   <= ch_sel;
		end
	end

	// Stage 1: s = prev_y + (x - prev_x) * 2^14, kept as sign and magnitude
	always_comb begin
		diff = 17'(x_q) - 17'(prev_x_q[ch_q]);
		sum  = {prev_y_q[ch_q][31], prev_y_q[ch_q]} + {{2{diff[16]}}, diff, 14'b0};
	end

	always_ff @(posedge clk) begin
		if (cmd.calc_sum) begin
			sneg_s1 <= sum[32];
			smag_s1 <= sum[32] ? 33'(-sum) : 33'(sum);
		end
	end

	// Stage 2: scale by alpha, truncate toward zero, saturate to 32 bits
	always_comb begin
		alpha_prod = 49'(smag_s1) * 49'(ALPHA_Q16);
		ym         = alpha_prod[48:16];
		if (!sneg_s1 && ym > Y_POS_MAX) begin
			ymag_sat = Y_POS_MAX[31:0];
		end else if (sneg_s1 && ym > Y_NEG_MAX) begin
			ymag_sat = Y_NEG_MAX[31:0];
		end else begin
			ymag_sat = ym[31:0];
		end
		y_new = sneg_s1 ? -$signed(ymag_sat) : $signed(ymag_sat);
	end

	always_ff @(posedge clk) begin
		if (cmd.calc_alpha) begin
			ymag_s2 <= ymag_sat;
			yneg_s2 <= sneg_s1 && (ymag_sat != '0);
		end
	end

	// Update the channel history with this sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				prev_x_q[i] <= '0;
				prev_y_q[i] <= '0;
			end
		end else if (cmd.calc_alpha) begin
			prev_x_q[ch_q] <= x_q;
			prev_y_q[ch_q] <= y_new;
		end
	end

	// Stage 3: apply the gain
	always_ff @(posedge clk) begin
		if (cmd.calc_gain) begin
			vmag_s3 <= 48'(ymag_s2) * 48'(gain_q);
			vneg_s3 <= yneg_s2;
		end
	end

	// Saturate to int16 and truncate toward zero
	always_comb begin
		q = vmag_s3[37:22];
		out_next.last_out = last_q;
		if (!vneg_s3 && vmag_s3 > POS_LIMIT) begin
			out_next.sample_out = 16'sh7FFF;
			out_next.clipped    = 1'b1;
		end else if (vneg_s3 && vmag_s3 > NEG_LIMIT) begin
			out_next.sample_out = -16'sh8000;
			out_next.clipped    = 1'b1;
		end else begin
			out_next.sample_out = vneg_s3 ? -$signed(q) : $signed(q);
			out_next.clipped    = 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= out_next;
		end
	end

	assign out_item = out_q;

endmodule

### rtl/dcbg_ctrl.sv
// Controller: sequences one item through sum, alpha and gain steps and owns the output valid.
module dcbg_ctrl import dcbg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	output dp_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SUM   = 3'd1;
	localparam logic [2:0] ST_ALPHA = 3'd2;
	localparam logic [2:0] ST_GAIN  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_next;
	logic       out_valid_q;
	logic       load_ok;
	logic       can_take;

	// Output register may load when empty or being drained this cycle
	assign load_ok  = !out_valid_q || !out_stall;
	assign can_take = (state_q == ST_IDLE) || (state_q == ST_DONE && load_ok);
	assign in_stall = !can_take;

	// Issue datapath commands
	always_comb begin
		cmd            = '0;
		cmd.accept     = in_valid && can_take;
		cmd.calc_sum   = (state_q == ST_SUM);
		cmd.calc_alpha = (state_q == ST_ALPHA);
		cmd.calc_gain  = (state_q == ST_GAIN);
		cmd.load_out   = (state_q == ST_DONE) && load_ok;
	end

	// Advance the sequence
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_SUM;
			end
			ST_SUM:   state_next = ST_ALPHA;
			ST_ALPHA: state_next = ST_GAIN;
			ST_GAIN:  state_next = ST_DONE;
			ST_DONE: begin
				if (load_ok) state_next = in_valid ? ST_SUM : ST_IDLE;
			end
			default:  state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// An accepted item always starts at the sum step
	a_accept_to_sum: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == ST_SUM)
		else $error("accepted item did not enter the sum step");

	// Steps follow in fixed order
	a_sum_to_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SUM |=> state_q == ST_ALPHA && $past(cmd.calc_sum))
		else $error("sum step not followed by alpha step");

	// A load never overwrites a result still held by a stall
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid_q && out_stall))
		else $error("output register overwritten while stalled");

	// A loaded result is presented next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("loaded result not presented");

endmodule

### rtl/dc_block_gain_saturate_core.sv
// From input accept to output valid an item passes the sum, alpha multiply, gain multiply and load
//   steps; the load waits while a held result is stalled. The shared controller sequence works on one
//   item at a time; a new item is taken in the same cycle the previous result loads.
// The output register holds a finished result while the next item is worked on.
// Reset (arst_n low, asynchronous): gain returns to 1.0, channel counter and all
//   filter histories clear, no result is pending.
module dc_block_gain_saturate_core import dcbg_pkg::*; #(
	parameter int NUM_CHANNELS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item,
	input  logic        gain_we,
	input  logic [15:0] gain_wdata
);

	dp_cmd_t cmd;

	// Sequence control
	dcbg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Filter arithmetic and history
	dcbg_datapath #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_item    (in_item),
		.gain_we    (gain_we),
		.gain_wdata (gain_wdata),
		.out_item   (out_item)
	);

endmodule
